@@ rtl/omon_pkg.sv @@
// shared types, constants and channel lookup for the overcurrent monitor
package omon_pkg;

  localparam int NUM_MON    = 5;
  localparam int MON_IDX_W  = $clog2(NUM_MON);
  localparam int CH_W       = 4;
  localparam int SAMPLE_W   = 12;
  localparam int MA_W       = 11;
  localparam int FAULT_W    = NUM_MON;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MA_W;

  localparam int SCALE_MUL   = 330;
  localparam int SCALE_DIV   = 819;
  localparam int MA_MAX      = 1650;

  // avg * 330 / 819 as avg * ceil(330 * 2^22 / 819) >> 22, exact for every 12-bit average
  localparam int SCALE_SHIFT   = 22;
  localparam int SCALE_RECIP_W = 21;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = SCALE_RECIP_W'(
    ((longint'(SCALE_MUL) << SCALE_SHIFT) + longint'(SCALE_DIV) - 64'sd1)
    / longint'(SCALE_DIV));
  localparam int PROD_W = SAMPLE_W + SCALE_RECIP_W;

  localparam int MAX_FRAME_SAMPLES_DEF = 256;

  localparam logic [MA_W-1:0] LIMIT_RESET = 11'd2047;

  // slot order of the per-channel state, also the register and fault bit order
  localparam logic [MON_IDX_W-1:0] MON_PLATE      = 3'd0;
  localparam logic [MON_IDX_W-1:0] MON_SCOOP_MOVE = 3'd1;
  localparam logic [MON_IDX_W-1:0] MON_SCOOP_SPIN = 3'd2;
  localparam logic [MON_IDX_W-1:0] MON_MAIN       = 3'd3;
  localparam logic [MON_IDX_W-1:0] MON_WASTE      = 3'd4;
  localparam logic [MON_IDX_W-1:0] MON_LAST       = MON_WASTE;

  // adc channel tags of the monitored motors
  localparam logic [CH_W-1:0] CH_PLATE      = 4'd1;
  localparam logic [CH_W-1:0] CH_SCOOP_MOVE = 4'd2;
  localparam logic [CH_W-1:0] CH_SCOOP_SPIN = 4'd6;
  localparam logic [CH_W-1:0] CH_MAIN       = 4'd3;
  localparam logic [CH_W-1:0] CH_WASTE      = 4'd9;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } in_item_t;

  typedef struct packed {
    logic [MA_W-1:0]    scoop_move_ma;
    logic [MA_W-1:0]    plate_cur;
    logic [MA_W-1:0]    main_ma;
    logic [MA_W-1:0]    waste_cur;
    logic [MA_W-1:0]    scoop_spin_ma;
    logic [FAULT_W-1:0] fault_bits;
  } out_item_t;

  typedef struct packed {
    logic                 hit;
    logic [MON_IDX_W-1:0] idx;
  } mon_hit_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_AVG,
    S_MUL,
    S_OUTPUT
  } state_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic                 ready;
    logic                 div_start;
    logic                 load_prod;
    logic                 write_current;
    logic                 load_out;
    logic [MON_IDX_W-1:0] idx;
  } ctl_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic start_frame;
    logic count_nz;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic mon_hit_t mon_lookup(input logic [CH_W-1:0] ch);
    mon_hit_t r;
    r.hit = 1'b1;
    r.idx = MON_PLATE;
    case (ch)
      CH_PLATE:      r.idx = MON_PLATE;
      CH_SCOOP_MOVE: r.idx = MON_SCOOP_MOVE;
      CH_SCOOP_SPIN: r.idx = MON_SCOOP_SPIN;
      CH_MAIN:       r.idx = MON_MAIN;
      CH_WASTE:      r.idx = MON_WASTE;
      default:       r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/omon_div.sv @@
// shared restoring divider, one quotient bit per cycle
module omon_div #(
  parameter int DIVIDEND_W = 21,
  parameter int DIVISOR_W  = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] quo_next;

  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_W-1]};
    diff      = rem_shift - {1'b0, dvs};
    fits      = rem_shift >= {1'b0, dvs};
    rem_next  = fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    quo_next  = {quo[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/omon_fsm.sv @@
// frame evaluation sequencer: walks the five channels, sending each one with samples through the divider
module omon_fsm (
  input  logic           clk,
  input  logic           rst,
  input  omon_pkg::stat_t stat,
  output omon_pkg::ctl_t  ctl
);

  omon_pkg::state_t state;
  omon_pkg::state_t state_next;
  logic [omon_pkg::MON_IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= omon_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == omon_pkg::S_IDLE) begin
        idx <= '0;
      end else if ((state == omon_pkg::S_CHECK && !stat.count_nz && idx != omon_pkg::MON_LAST)
                   || (state == omon_pkg::S_MUL && idx != omon_pkg::MON_LAST)) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      omon_pkg::S_IDLE: begin
        if (stat.start_frame) state_next = omon_pkg::S_CHECK;
      end
      omon_pkg::S_CHECK: begin
        if (stat.count_nz) state_next = omon_pkg::S_DIV_AVG;
        else if (idx == omon_pkg::MON_LAST) state_next = omon_pkg::S_OUTPUT;
      end
      omon_pkg::S_DIV_AVG: begin
        if (stat.div_done) state_next = omon_pkg::S_MUL;
      end
      omon_pkg::S_MUL: begin
        state_next = (idx == omon_pkg::MON_LAST) ? omon_pkg::S_OUTPUT : omon_pkg::S_CHECK;
      end
      omon_pkg::S_OUTPUT: begin
        if (stat.out_free) state_next = omon_pkg::S_IDLE;
      end
      default: state_next = omon_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl               = '0;
    ctl.idx           = idx;
    ctl.ready         = (state == omon_pkg::S_IDLE);
    ctl.div_start     = (state == omon_pkg::S_CHECK) && stat.count_nz;
    ctl.load_prod     = (state == omon_pkg::S_DIV_AVG) && stat.div_done;
    ctl.write_current = (state == omon_pkg::S_MUL);
    ctl.load_out      = (state == omon_pkg::S_OUTPUT) && stat.out_free;
  end

endmodule

@@ rtl/multichannel_overcurrent_monitor.sv @@
// top level: per-channel accumulation, shared divider datapath and result register
//
//  port group   direction  handshake              payload
//  in_*         sink       in_valid / in_stall    omon_pkg::in_item_t
//  out_*        source     out_valid / out_stall  omon_pkg::out_item_t
//  cfg_*        sink       cfg_we                 cfg_index, cfg_data (limits)
//
// an ordinary sample is summed in the cycle it is accepted, and the next one can follow at once
// a frame_end sample holds in_stall high while each channel with samples takes one
// divider pass for its average and a reciprocal multiply for the 330/819 scaling;
// empty channels are skipped, and the divider works on the sum width (20 bits by default);
// the result is then loaded, held back while the previous result is stalled
// reset is synchronous and clears sums, counts, currents and faults; limits go to 2047
module multichannel_overcurrent_monitor #(
  parameter int MAX_FRAME_SAMPLES = omon_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  omon_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output omon_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [omon_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [omon_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = $clog2(MAX_FRAME_SAMPLES * ((1 << omon_pkg::SAMPLE_W) - 1) + 1);
  localparam logic [CNT_W-1:0] FRAME_MAX = CNT_W'(MAX_FRAME_SAMPLES);

  logic [SUM_W-1:0]          sums     [omon_pkg::NUM_MON];
  logic [CNT_W-1:0]          counts   [omon_pkg::NUM_MON];
  logic [omon_pkg::MA_W-1:0] currents [omon_pkg::NUM_MON];
  logic [omon_pkg::MA_W-1:0] limits   [omon_pkg::NUM_MON];
  logic [omon_pkg::FAULT_W-1:0] faults;
  logic [CNT_W-1:0]          frame_taken;
  logic [omon_pkg::PROD_W-1:0] prod;

  omon_pkg::ctl_t   ctl;
  omon_pkg::stat_t  stat;
  omon_pkg::mon_hit_t mon;

  logic                           accept;
  logic                           frame_open;
  logic [omon_pkg::MON_IDX_W-1:0] sel_idx;
  logic [SUM_W-1:0]               sum_rd;
  logic [CNT_W-1:0]               cnt_rd;
  logic                           div_done;
  logic [SUM_W-1:0]               div_q;
  logic [omon_pkg::MA_W-1:0]      ma;

  assign in_stall   = !ctl.ready;
  assign accept     = in_valid && !in_stall;
  assign mon        = omon_pkg::mon_lookup(in_data.channel);
  assign frame_open = frame_taken < FRAME_MAX;

  // one read port: the sample's slot while idle, the sequencer's slot otherwise
  assign sel_idx = ctl.ready ? mon.idx : ctl.idx;
  assign sum_rd  = sums[sel_idx];
  assign cnt_rd  = counts[sel_idx];

  assign ma = prod[omon_pkg::SCALE_SHIFT +: omon_pkg::MA_W];

  assign stat.start_frame = accept && in_data.frame_end;
  assign stat.count_nz    = cnt_rd != '0;
  assign stat.div_done    = div_done;
  assign stat.out_free    = !out_valid || !out_stall;

  omon_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  omon_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (sum_rd),
    .divisor  (cnt_rd),
    .done     (div_done),
    .quotient (div_q)
  );

  // accumulation, frame clear when the result is loaded
  always_ff @(posedge clk) begin
    if (rst || ctl.load_out) begin
      for (int i = 0; i < omon_pkg::NUM_MON; i++) begin
        sums[i]   <= '0;
        counts[i] <= '0;
      end
      frame_taken <= '0;
    end else if (accept && frame_open) begin
      frame_taken <= frame_taken + 1'b1;
      if (mon.hit) begin
        sums[mon.idx]   <= sum_rd + SUM_W'(in_data.sample);
        counts[mon.idx] <= cnt_rd + 1'b1;
      end
    end
  end

  // average times the scaled reciprocal of 819/330; the current is the top bits
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod <= omon_pkg::PROD_W'(div_q[omon_pkg::SAMPLE_W-1:0])
              * omon_pkg::PROD_W'(omon_pkg::SCALE_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < omon_pkg::NUM_MON; i++) begin
        currents[i] <= '0;
        limits[i]   <= omon_pkg::LIMIT_RESET;
      end
      faults <= '0;
    end else begin
      if (cfg_we && cfg_index < omon_pkg::CFG_IDX_W'(omon_pkg::NUM_MON)) begin
        limits[cfg_index] <= cfg_data;
      end
      if (ctl.write_current) begin
        currents[ctl.idx] <= ma;
        if (ma > limits[ctl.idx]) faults[ctl.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_data  <= '0;
    end else if (ctl.load_out) begin
      out_valid              <= 1'b1;
      out_data.scoop_move_ma <= currents[omon_pkg::MON_SCOOP_MOVE];
      out_data.plate_cur     <= currents[omon_pkg::MON_PLATE];
      out_data.main_ma       <= currents[omon_pkg::MON_MAIN];
      out_data.waste_cur     <= currents[omon_pkg::MON_WASTE];
      out_data.scoop_spin_ma <= currents[omon_pkg::MON_SCOOP_SPIN];
      out_data.fault_bits    <= faults;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/omon_chk.sv @@
// port-level checker for the overcurrent monitor, bound to the top level
module omon_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input omon_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input omon_pkg::out_item_t out_data
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a frame-ending transaction starts evaluation, so the input side must stall
  a_eval_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.frame_end |=> in_stall)
    else $error("input not stalled during frame evaluation");

  // scaled currents never exceed full-scale
  a_ma_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.plate_cur <= 11'd1650) && (out_data.scoop_move_ma <= 11'd1650)
                  && (out_data.scoop_spin_ma <= 11'd1650) && (out_data.main_ma <= 11'd1650)
                  && (out_data.waste_cur <= 11'd1650))
    else $error("current out of range");

  // fault bits are sticky between resets
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((out_data.fault_bits & $past(out_data.fault_bits))
                     == $past(out_data.fault_bits)))
    else $error("fault bit cleared without reset");

endmodule

bind multichannel_overcurrent_monitor omon_chk u_omon_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
